[hdl/md5d_pkg.sv]
// MD5 digest engine package: sequencer states, chaining word type,
// initial values, padding constants and the per-round constant tables.
// No dependencies; used by md5d_round and md5_digest_engine.
package md5d_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,   // taking message words
        ST_ROUND,  // one compression round per cycle
        ST_ADD,    // fold working words into the chaining words
        ST_PAD,    // writing padding and length words
        ST_OUT     // load the digest register
    } md5d_state_t;

    // Four 32-bit words of chaining or working state
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } md5d_words_t;

    localparam logic [31:0] IV_A = 32'h6745_2301;
    localparam logic [31:0] IV_B = 32'hEFCD_AB89;
    localparam logic [31:0] IV_C = 32'h98BA_DCFE;
    localparam logic [31:0] IV_D = 32'h1032_5476;

    localparam logic [31:0] PAD_WORD   = 32'h0000_0080;
    localparam logic [3:0]  LEN_LO_POS = 4'd14;
    localparam logic [3:0]  LEN_HI_POS = 4'd15;
    localparam logic [3:0]  LAST_POS   = 4'd15;
    localparam logic [5:0]  LAST_ROUND = 6'd63;

    // Sine-derived additive constant of each round
    function automatic logic [31:0] sine_const(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Left-rotate amount: depends on the quarter and the round mod 4
    function automatic logic [4:0] shift_amt(input logic [5:0] r);
        logic [4:0] s;
        unique case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word used by a round; products taken mod 16
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] g;
        logic [3:0] lo;
        lo = r[3:0];
        unique case (r[5:4])
            2'd0: g = lo;
            2'd1: g = 4'((lo << 2) + lo + 4'd1);
            2'd2: g = 4'((lo << 1) + lo + 4'd5);
            2'd3: g = 4'((lo << 3) - lo);
            default: g = lo;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {x, x} << s;
        return dbl[63:32];
    endfunction

endpackage

[hdl/md5d_round.sv]
// MD5 round unit: one compression round on the working words.
// Depends on md5d_pkg (word type, constant tables, rotate).
module md5d_round (
    input  logic [5:0]           round_idx,
    input  logic [31:0]          msg_word,
    input  md5d_pkg::md5d_words_t work_in,
    output md5d_pkg::md5d_words_t work_out
);

    logic [31:0] f_val;
    logic [31:0] sum;

    // Boolean function of the quarter
    always_comb begin
        unique case (round_idx[5:4])
            2'd0: f_val = (work_in.b & work_in.c) | (~work_in.b & work_in.d);
            2'd1: f_val = (work_in.d & work_in.b) | (~work_in.d & work_in.c);
            2'd2: f_val = work_in.b ^ work_in.c ^ work_in.d;
            2'd3: f_val = work_in.c ^ (work_in.b | ~work_in.d);
            default: f_val = '0;
        endcase
    end

    assign sum = work_in.a + f_val + md5d_pkg::sine_const(round_idx) + msg_word;

    // Word rotation with the new B
    always_comb begin
        work_out.a = work_in.d;
        work_out.d = work_in.c;
        work_out.c = work_in.b;
        work_out.b = work_in.b + md5d_pkg::rotl32(sum, md5d_pkg::shift_amt(round_idx));
    end

endmodule

[hdl/md5_digest_engine.sv]
// MD5 digest engine top level: word buffer, padding sequencer, chaining state
// and digest output register. Depends on md5d_pkg and md5d_round.
//
// Message words enter little-endian, first byte in bits 7:0, one transfer per
// cycle while s_tready is high. Every 16th word fills a block and starts the
// compression, which runs one round per cycle in a single shared round unit:
// 64 rounds, then a step that folds the result into the chaining words; all
// that time s_tready is low, so no new word is taken. The word marked by s_tlast
// carries 0..4 valid bytes (s_tdata[34:32], values above 4 count as 4); the
// engine then writes the 0x80 marker, zero words and the 64-bit bit length,
// one word per cycle between compressions, compressing one or two more
// blocks, and loads the 128-bit digest into an output register (word A in
// m_tdata[31:0]). The digest waits there for m_tready while the next message
// is already being taken in; a second digest is held back until the first
// has been transferred.
module md5_digest_engine (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // [31:0] data_word, [34:32] valid_bytes, [39:35] zero
    input  logic         s_tlast,   // last
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // [31:0] digest_a, [63:32] digest_b,
                                    // [95:64] digest_c, [127:96] digest_d
);

    md5d_pkg::md5d_state_t state_reg, state_next;

    logic [31:0]          buf_reg [16];
    logic [3:0]           pos_reg;
    logic [63:0]          bits_reg;
    logic [5:0]           round_reg;
    md5d_pkg::md5d_words_t chain_reg;
    md5d_pkg::md5d_words_t work_reg;
    md5d_pkg::md5d_words_t work_round;
    logic                 pad_active_reg;  // message padding in progress
    logic                 pad_done_reg;    // 0x80 marker written
    logic                 len_ok_reg;      // length fits in this block
    logic                 final_reg;       // length written, digest follows
    logic                 m_tvalid_reg;
    logic [127:0]         m_tdata_reg;

    logic        s_xfer;
    logic        buf_we;
    logic [31:0] buf_wdata;
    logic [31:0] in_word;
    logic [31:0] pad_word;
    logic [2:0]  nbytes;
    logic [31:0] last_word;
    logic        start_comp;
    logic        out_load;

    assign in_word = s_tdata[31:0];
    assign s_xfer  = s_tvalid && s_tready;

    // Saturated byte count of the last word
    assign nbytes = (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];

    // Last word: keep valid bytes, marker right after them
    always_comb begin
        unique case (nbytes)
            3'd0: last_word = md5d_pkg::PAD_WORD;
            3'd1: last_word = {16'h0, md5d_pkg::PAD_WORD[7:0], in_word[7:0]};
            3'd2: last_word = {8'h0, md5d_pkg::PAD_WORD[7:0], in_word[15:0]};
            3'd3: last_word = {md5d_pkg::PAD_WORD[7:0], in_word[23:0]};
            default: last_word = in_word;
        endcase
    end

    // Padding word for the current slot
    always_comb begin
        priority if (!pad_done_reg) begin
            pad_word = md5d_pkg::PAD_WORD;
        end else if (len_ok_reg && pos_reg == md5d_pkg::LEN_LO_POS) begin
            pad_word = bits_reg[31:0];
        end else if (len_ok_reg && pos_reg == md5d_pkg::LEN_HI_POS) begin
            pad_word = bits_reg[63:32];
        end else begin
            pad_word = '0;
        end
    end

    // Buffer write source
    always_comb begin
        buf_we    = 1'b0;
        buf_wdata = pad_word;
        if (s_xfer) begin
            buf_we    = 1'b1;
            buf_wdata = s_tlast ? last_word : in_word;
        end else if (state_reg == md5d_pkg::ST_PAD) begin
            buf_we = 1'b1;
        end
    end

    assign start_comp = buf_we && (pos_reg == md5d_pkg::LAST_POS);
    assign out_load   = (state_reg == md5d_pkg::ST_OUT) && (!m_tvalid_reg || m_tready);

    md5d_round u_round (
        .round_idx (round_reg),
        .msg_word  (buf_reg[md5d_pkg::msg_index(round_reg)]),
        .work_in   (work_reg),
        .work_out  (work_round)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            md5d_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    if (start_comp) begin
                        state_next = md5d_pkg::ST_ROUND;
                    end else if (s_tlast) begin
                        state_next = md5d_pkg::ST_PAD;
                    end
                end
            end
            md5d_pkg::ST_ROUND: begin
                if (round_reg == md5d_pkg::LAST_ROUND) begin
                    state_next = md5d_pkg::ST_ADD;
                end
            end
            md5d_pkg::ST_ADD: begin
                priority if (final_reg) begin
                    state_next = md5d_pkg::ST_OUT;
                end else if (pad_active_reg) begin
                    state_next = md5d_pkg::ST_PAD;
                end else begin
                    state_next = md5d_pkg::ST_IDLE;
                end
            end
            md5d_pkg::ST_PAD: begin
                if (start_comp) begin
                    state_next = md5d_pkg::ST_ROUND;
                end
            end
            md5d_pkg::ST_OUT: begin
                if (out_load) begin
                    state_next = md5d_pkg::ST_IDLE;
                end
            end
            default: state_next = md5d_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        s_tready = (state_reg == md5d_pkg::ST_IDLE);
        m_tvalid = m_tvalid_reg;
        m_tdata  = m_tdata_reg;
    end

    // Block buffer
    always_ff @(posedge aclk) begin
        if (buf_we) begin
            buf_reg[pos_reg] <= buf_wdata;
        end
    end

    // Working words and digest data
    always_ff @(posedge aclk) begin
        if (start_comp) begin
            work_reg <= chain_reg;
        end else if (state_reg == md5d_pkg::ST_ROUND) begin
            work_reg <= work_round;
        end
        if (out_load) begin
            m_tdata_reg <= {chain_reg.d, chain_reg.c, chain_reg.b, chain_reg.a};
        end
    end

    // Control and chaining state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= md5d_pkg::ST_IDLE;
            pos_reg        <= '0;
            bits_reg       <= '0;
            round_reg      <= '0;
            chain_reg      <= '{md5d_pkg::IV_A, md5d_pkg::IV_B,
                                md5d_pkg::IV_C, md5d_pkg::IV_D};
            pad_active_reg <= 1'b0;
            pad_done_reg   <= 1'b0;
            len_ok_reg     <= 1'b0;
            final_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (buf_we) begin
                pos_reg <= pos_reg + 4'd1;
            end

            // Input transfer bookkeeping
            if (s_xfer) begin
                if (s_tlast) begin
                    bits_reg       <= bits_reg + {58'd0, nbytes, 3'd0};
                    pad_active_reg <= 1'b1;
                    pad_done_reg   <= (nbytes != 3'd4);
                    len_ok_reg     <= (nbytes != 3'd4) && (pos_reg < md5d_pkg::LEN_LO_POS);
                    final_reg      <= 1'b0;
                end else begin
                    bits_reg <= bits_reg + 64'd32;
                end
            end

            // Padding sequence
            if (state_reg == md5d_pkg::ST_PAD) begin
                if (!pad_done_reg) begin
                    pad_done_reg <= 1'b1;
                    len_ok_reg   <= (pos_reg < md5d_pkg::LEN_LO_POS);
                end else if (len_ok_reg && pos_reg == md5d_pkg::LEN_HI_POS) begin
                    final_reg <= 1'b1;
                end
            end

            // Rounds and chaining update
            if (state_reg == md5d_pkg::ST_ROUND) begin
                round_reg <= round_reg + 6'd1;
            end
            if (state_reg == md5d_pkg::ST_ADD) begin
                chain_reg.a <= chain_reg.a + work_reg.a;
                chain_reg.b <= chain_reg.b + work_reg.b;
                chain_reg.c <= chain_reg.c + work_reg.c;
                chain_reg.d <= chain_reg.d + work_reg.d;
                if (pad_done_reg) begin
                    len_ok_reg <= 1'b1;
                end
            end

            // Digest hand-off and restart
            if (out_load) begin
                m_tvalid_reg   <= 1'b1;
                chain_reg      <= '{md5d_pkg::IV_A, md5d_pkg::IV_B,
                                    md5d_pkg::IV_C, md5d_pkg::IV_D};
                bits_reg       <= '0;
                pad_active_reg <= 1'b0;
                pad_done_reg   <= 1'b0;
                len_ok_reg     <= 1'b0;
                final_reg      <= 1'b0;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Round counter only moves inside the compression
    a_round_in_comp: assert property (@(posedge aclk) disable iff (!aresetn)
        round_reg != 6'd0 |-> state_reg == md5d_pkg::ST_ROUND)
        else $error("round counter nonzero outside compression");

    // Final round is always followed by the chaining add
    a_round_to_add: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == md5d_pkg::ST_ROUND && round_reg == md5d_pkg::LAST_ROUND)
        |=> state_reg == md5d_pkg::ST_ADD)
        else $error("compression did not end in chaining add");

    // A new digest only appears from the output-load step
    a_digest_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == md5d_pkg::ST_OUT)
        else $error("digest raised outside output load");

    // Message restarts cleanly after a digest is loaded
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (pos_reg == 4'd0 && bits_reg == 64'd0 && !pad_active_reg))
        else $error("engine state not restarted after digest");

    // Compression only begins at the end of a block
    a_block_full: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == md5d_pkg::ST_ROUND) |-> pos_reg == 4'd0)
        else $error("compression started on a partial block");

endmodule

[dv/md5_digest_engine_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for md5_digest_engine: directed table, then random messages,
// checked against an in-bench MD5 model or a known digest. Depends on md5d_pkg, RTL.
module md5_digest_engine_tb;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int ITEM_TARGET    = 1650;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int MAX_PRINTS     = 60;

    // Receiver stall patterns
    localparam int RX_OPEN   = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_BURSTY = 2;

    // Per-round additive constants and left-rotate amounts
    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int ROUND_ROT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                      4, 11, 16, 23, 6, 10, 15, 21};

    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        last;
        logic        typed;     // digest below is known by heart
        md5d_pkg::md5d_words_t want;
    } stim_row_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [39:0]  s_tdata  = '0;    // [31:0] data_word, [34:32] valid_bytes, [39:35] zero
    logic         s_tlast  = 1'b0;  // last
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;          // [31:0] digest_a, [63:32] digest_b,
                                    // [95:64] digest_c, [127:96] digest_d

    // Digest model state
    logic [31:0] chain_state [4];
    logic [31:0] block_words [16];
    logic [3:0]  word_slot;
    logic [63:0] bit_total;

    md5d_pkg::md5d_words_t pending_digests [$];
    stim_row_t   dir_rows [$];
    int          mismatch_count = 0;
    int          digest_count   = 0;
    int          item_count     = 0;
    int          burst_left     = 0;
    int          idle_cycles    = 0;
    int          rx_cycle       = 0;
    int          rx_mode        = RX_OPEN;

    md5_digest_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // ---------------- digest model ----------------

    function automatic logic [31:0] rotate_left(input logic [31:0] x, input int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    task automatic restart_chain();
        chain_state[0] = md5d_pkg::IV_A;
        chain_state[1] = md5d_pkg::IV_B;
        chain_state[2] = md5d_pkg::IV_C;
        chain_state[3] = md5d_pkg::IV_D;
        word_slot      = '0;
        bit_total      = '0;
    endtask

    // 64 rounds over the buffered block, then fold into the chain
    task automatic compress_block();
        logic [31:0] a, b, c, d, f, t, sum;
        int g;
        a = chain_state[0];
        b = chain_state[1];
        c = chain_state[2];
        d = chain_state[3];
        for (int r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1: begin
                    f = (d & b) | (~d & c);
                    g = (5 * r + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            sum = a + f + ROUND_K[r] + block_words[g];
            t = d;
            d = c;
            c = b;
            b = b + rotate_left(sum, ROUND_ROT[(r / 16) * 4 + r % 4]);
            a = t;
        end
        chain_state[0] += a;
        chain_state[1] += b;
        chain_state[2] += c;
        chain_state[3] += d;
    endtask

    task automatic absorb_word(input logic [31:0] w);
        block_words[word_slot] = w;
        word_slot = word_slot + 4'd1;
        if (word_slot == 4'd0)
            compress_block();
    endtask

    // One accepted word; on the last word, pad, append the length and emit the digest
    task automatic digest_step(input logic [31:0] data, input logic [2:0] nbytes_in,
                               input logic last, output bit produced,
                               output md5d_pkg::md5d_words_t dig);
        int nb;
        logic [31:0] keep;
        produced = 1'b0;
        dig = '0;
        if (!last) begin
            bit_total += 64'd32;
            absorb_word(data);
        end else begin
            nb = (nbytes_in > 3'd4) ? 4 : int'(nbytes_in);
            bit_total += 64'(nb * 8);
            if (nb == 4) begin
                absorb_word(data);
                absorb_word(md5d_pkg::PAD_WORD);
            end else begin
                keep = (nb == 0) ? 32'h0 : (32'hFFFF_FFFF >> (32 - 8 * nb));
                absorb_word((data & keep) | (md5d_pkg::PAD_WORD << (8 * nb)));
            end
            // no room for the length: flush an extra block
            if (word_slot > md5d_pkg::LEN_LO_POS) begin
                while (word_slot != 4'd0)
                    absorb_word('0);
            end
            while (word_slot != md5d_pkg::LEN_LO_POS)
                absorb_word('0);
            absorb_word(bit_total[31:0]);
            absorb_word(bit_total[63:32]);
            dig.a = chain_state[0];
            dig.b = chain_state[1];
            dig.c = chain_state[2];
            dig.d = chain_state[3];
            produced = 1'b1;
            restart_chain();
        end
    endtask

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("[%0t] digest %0d %s: got %08h expected %08h",
                     $realtime, digest_count, what, got, want);
    endtask

    // Result compare plus the no-progress watchdog
    always @(posedge aclk) begin : result_check
        md5d_pkg::md5d_words_t want;
        logic [127:0] want_bus;
        string field_name [4];
        field_name = '{"digest_a", "digest_b", "digest_c", "digest_d"};
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_digests.size() == 0) begin
                report_mismatch("with none expected", m_tdata[31:0], '0);
            end else begin
                want = pending_digests.pop_front();
                want_bus = {want.d, want.c, want.b, want.a};
                for (int w = 0; w < 4; w++) begin
                    if (m_tdata[32*w +: 32] !== want_bus[32*w +: 32])
                        report_mismatch(field_name[w], m_tdata[32*w +: 32],
                                        want_bus[32*w +: 32]);
                end
            end
            digest_count++;
        end

        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------- receiver ----------------

    // Stall pattern is redrawn at random from open, random and bursty
    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 256 == 0)
            rx_mode <= $urandom_range(RX_OPEN, RX_BURSTY);
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
            default:   m_tready <= ((rx_cycle % 41) < 12);
        endcase
    end

    // ---------------- sender ----------------

    // Drive one word at a falling edge, after an occasional random gap, and wait for its transfer
    task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes,
                             input logic last, input logic typed,
                             input md5d_pkg::md5d_words_t typed_want);
        int gap;
        bit produced;
        md5d_pkg::md5d_words_t dig;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, nbytes, data};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        digest_step(data, nbytes, last, produced, dig);
        if (produced)
            pending_digests = {pending_digests, (typed ? typed_want : dig)};
        item_count++;
        @(negedge aclk);
    endtask

    // Hold off until every expected digest has come out
    task automatic wait_all_digests();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_digests.size() != 0)
            @(negedge aclk);
    endtask

    task automatic add_row(input logic [31:0] data, input logic [2:0] nbytes,
                           input logic last, input logic typed,
                           input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] c, input logic [31:0] d);
        stim_row_t row;
        row.data   = data;
        row.nbytes = nbytes;
        row.last   = last;
        row.typed  = typed;
        row.want   = '{a: a, b: b, c: c, d: d};
        dir_rows   = {dir_rows, row};
    endtask

    // Random message: lengths clustered around the padding boundaries
    task automatic send_random_message();
        int len;
        int pick;
        logic [31:0] data;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            len = $urandom_range(1, 16);
        else if (pick < 70)
            len = $urandom_range(13, 18);
        else if (pick < 92)
            len = $urandom_range(17, 40);
        else
            len = $urandom_range(41, 100);
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                data = '0;
            else if (pick == 1)
                data = '1;
            else
                data = $urandom;
            send_word(data, 3'($urandom_range(0, 7)), (i == len - 1), 1'b0, '0);
        end
    endtask

    initial begin
        int msg_count;
        msg_count = 0;
        restart_chain();
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Single-word messages: empty (bytes past count ignored), "abc", extremes
        add_row(32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1,
                32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec);
        add_row(32'hFF63_6261, 3'd3, 1'b1, 1'b1,
                32'h98500190, 32'hb04fd23c, 32'h7d3f96d6, 32'h727fe128);
        add_row(32'h0000_0000, 3'd4, 1'b1, 1'b0, '0, '0, '0, '0);
        add_row(32'hFFFF_FFFF, 3'd7, 1'b1, 1'b0, '0, '0, '0, '0);
        // 14 full words with assorted byte counts (ignored), then a 1-byte tail:
        // the length no longer fits, so an extra block is flushed
        add_row(32'h0000_0000, 3'd0, 1'b0, 1'b0, '0, '0, '0, '0);
        add_row(32'hFFFF_FFFF, 3'd1, 1'b0, 1'b0, '0, '0, '0, '0);
        for (int i = 2; i < 14; i++)
            add_row(32'h9E37_79B9 * (i + 1), 3'(i), 1'b0, 1'b0, '0, '0, '0, '0);
        add_row(32'hDEAD_BE5A, 3'd1, 1'b1, 1'b0, '0, '0, '0, '0);

        foreach (dir_rows[i])
            send_word(dir_rows[i].data, dir_rows[i].nbytes, dir_rows[i].last,
                      dir_rows[i].typed, dir_rows[i].want);
        wait_all_digests();

        while (item_count < ITEM_TARGET) begin
            send_random_message();
            msg_count++;
            if (msg_count == 25)
                wait_all_digests();
        end

        wait_all_digests();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_digests.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
